>>> src/block_circular_correlation_filter_top_macros.svh
// ----------------------------------------------------------------------------
// Block circular correlation filter - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CIRCULAR_CORRELATION_FILTER_TOP_MACROS_SVH
`define BLOCK_CIRCULAR_CORRELATION_FILTER_TOP_MACROS_SVH

// checked outside reset only
`define CCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked in every cycle, reset included
`define CCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Constants, types and codes shared by the correlation filter modules.
// ----------------------------------------------------------------------------
package ccf_pkg;

  localparam int TAPS        = 7;
  localparam int HEAD        = TAPS - 1;
  localparam int MAX_WINDOW  = 1024;
  localparam int MIN_WINDOW  = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int TAP_W       = 16;
  localparam int TAP_FRAC    = 15;
  localparam int WIN_W       = 11;
  localparam int POS_W       = $clog2(MAX_WINDOW);
  localparam int J_W         = POS_W + 1;
  localparam int TI_W        = $clog2(TAPS);
  localparam int HI_W        = $clog2(HEAD);
  localparam int K_W         = $clog2(TAPS + 2);
  localparam int K_LAST      = TAPS + 1;
  localparam int PROD_W      = SAMPLE_BITS + TAP_W;
  localparam int ACC_W       = PROD_W + $clog2(TAPS) + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(128);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAP_0       = CFG_IDX_W'(1);

  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] i;
    logic signed [SAMPLE_BITS-1:0] q;
  } sample_t;

  typedef struct packed {
    logic           load;
    logic           issue;
    logic           clear;
    logic           emit;
    logic [K_W-1:0] k;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic last_result;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/ccf_ctrl.sv
// ----------------------------------------------------------------------------
// ccf_ctrl
// Sequencer: takes a sample, then runs one tap-serial MAC pass per result.
// ----------------------------------------------------------------------------
module ccf_ctrl import ccf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [K_W-1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd        = '0;
    cmd.k      = k;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && status.has_result) begin
          state_next = ST_MAC;
          k_next     = '0;
        end
      end
      ST_MAC: begin
        cmd.issue = (k < K_W'(TAPS));
        cmd.clear = (k == '0);
        if (k == K_W'(K_LAST)) begin
          state_next = ST_EMIT;
        end else begin
          k_next = k + K_W'(1);
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          k_next   = '0;
          state_next = status.last_result ? ST_IDLE : ST_MAC;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/ccf_datapath.sv
// ----------------------------------------------------------------------------
// ccf_datapath
// Sample stores, operand select, I/Q multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module ccf_datapath import ccf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  ctrl_cmd_t                     cmd,
  output dp_status_t                    status,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  input  logic                          end_of_message,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q,
  output logic                          window_done,
  output logic                          message_done,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  logic [WIN_W-1:0]        window_size;
  logic signed [TAP_W-1:0] tap [TAPS];
  sample_t                 head_samples [HEAD];
  sample_t                 recent_samples [TAPS];
  logic [POS_W-1:0]        position;

  logic [POS_W-1:0]        p_cur;
  logic [POS_W-1:0]        m;
  logic                    close_r;
  logic                    eom_r;

  sample_t                 op;
  logic signed [TAP_W-1:0] op_tap;
  logic                    op_vld;
  logic signed [PROD_W-1:0] prod_i, prod_q;
  logic                    prod_vld;
  logic signed [ACC_W-1:0] acc_i, acc_q;

  logic [WIN_W-1:0]        w_eff;
  logic [POS_W-1:0]        p_in;
  logic                    close_in;
  logic [J_W-1:0]          j_raw, j;
  logic [POS_W-1:0]        d;
  sample_t                 op_next;
  logic                    last_result;

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W:0]          v;
    logic signed [ACC_W-TAP_FRAC:0] qt;
    v  = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (TAP_FRAC - 1));
    qt = v[ACC_W:TAP_FRAC];
    if (qt > SAT_MAX) begin
      return SAT_MAX;
    end else if (qt < SAT_MIN) begin
      return SAT_MIN;
    end
    return qt[SAMPLE_BITS-1:0];
  endfunction

  always_comb begin
    if (window_size < WIN_W'(MIN_WINDOW)) begin
      w_eff = WIN_W'(MIN_WINDOW);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = window_size;
    end
    if ({1'b0, position} >= w_eff) begin
      p_in = POS_W'(w_eff - WIN_W'(1));
    end else begin
      p_in = position;
    end
    close_in = ({1'b0, p_in} == w_eff - WIN_W'(1)) || end_of_message;
  end

  assign last_result        = !close_r || (m == p_cur);
  assign status.has_result  = close_in || (p_in >= POS_W'(HEAD));
  assign status.last_result = last_result;
  assign status.out_free    = !out_valid || out_ready;

  // operand x[(m+k) mod W], zero past the last received sample
  always_comb begin
    j_raw   = {1'b0, m} + J_W'(cmd.k);
    j       = (j_raw >= w_eff) ? j_raw - w_eff : j_raw;
    d       = p_cur - j[POS_W-1:0];
    op_next = '0;
    if (j <= {1'b0, p_cur}) begin
      if (d < POS_W'(TAPS)) begin
        op_next = recent_samples[d[TI_W-1:0]];
      end else if (j < J_W'(HEAD)) begin
        op_next = head_samples[j[HI_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      position    <= '0;
      for (int t = 0; t < TAPS; t++) begin
        tap[t]            <= '0;
        recent_samples[t] <= '0;
      end
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_WINDOW_SIZE) begin
          window_size <= cfg_data[WIN_W-1:0];
          position    <= '0;
          for (int t = 0; t < TAPS; t++) begin
            recent_samples[t] <= '0;
          end
        end else if ({1'b0, cfg_index} <
                     (CFG_IDX_W+1)'(REG_TAP_0) + (CFG_IDX_W+1)'(TAPS)) begin
          tap[TI_W'(cfg_index - REG_TAP_0)] <= cfg_data[TAP_W-1:0];
        end
      end
      if (cmd.load) begin
        for (int t = 1; t < TAPS; t++) begin
          recent_samples[t] <= recent_samples[t-1];
        end
        recent_samples[0] <= '{i: sample_i, q: sample_q};
        position <= close_in ? '0 : p_in + POS_W'(1);
      end
      if (cmd.emit && close_r && last_result) begin
        for (int t = 0; t < TAPS; t++) begin
          recent_samples[t] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (p_in < POS_W'(HEAD)) begin
        head_samples[p_in[HI_W-1:0]] <= '{i: sample_i, q: sample_q};
      end
      p_cur   <= p_in;
      close_r <= close_in;
      eom_r   <= end_of_message;
      m       <= (p_in >= POS_W'(HEAD)) ? p_in - POS_W'(HEAD) : '0;
    end else if (cmd.emit) begin
      m <= m + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      op_vld   <= cmd.issue;
      prod_vld <= op_vld;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    op_tap <= tap[cmd.k[TI_W-1:0]];
    prod_i <= op.i * op_tap;
    prod_q <= op.q * op_tap;
    if (cmd.clear) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (prod_vld) begin
      acc_i <= acc_i + ACC_W'(prod_i);
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_i        <= round_sat(acc_i);
      out_q        <= round_sat(acc_q);
      window_done  <= close_r && last_result;
      message_done <= close_r && last_result && eom_r;
    end
  end

endmodule

>>> src/block_circular_correlation_filter_top.sv
// ----------------------------------------------------------------------------
// block_circular_correlation_filter_top
// Windowed circular cross-correlation of complex samples with 7 real taps.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one complex sample per beat, with
// end_of_message on the last sample of a message. Output channel
// (out_valid/out_ready): one filtered sample per beat, window_done and
// message_done flag the last result of a window and of a message.
// Config: cfg_write/cfg_index/cfg_data, index 0 is window_size, 1..7 the taps;
// write only while the block is idle.
// Each result takes one tap-serial MAC pass through the single I/Q multiplier
// pair, then a load of the output register.
// A sample that yields no result is taken while the sequencer stays idle; one
// that yields a result is followed by a MAC pass; a sample that closes a
// window yields up to 7 results, one MAC pass each.
// The output register lets a new sample be taken while a result waits; a
// stalled receiver holds the next result in the sequencer until taken.
// Reset (synchronous) restores window_size 128, zero taps, an empty window
// and an empty output register.
// ----------------------------------------------------------------------------
module block_circular_correlation_filter_top import ccf_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  input  logic                          end_of_message,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_i,
  output logic signed [SAMPLE_BITS-1:0] out_q,
  output logic                          window_done,
  output logic                          message_done,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ccf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ccf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample_i       (sample_i),
    .sample_q       (sample_q),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_i          (out_i),
    .out_q          (out_q),
    .window_done    (window_done),
    .message_done   (message_done),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

>>> src/ccf_checker.sv
// ----------------------------------------------------------------------------
// ccf_checker
// Port-level checks on the correlation filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_circular_correlation_filter_top_macros.svh"

module ccf_checker import ccf_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_i,
  input logic signed [SAMPLE_BITS-1:0] sample_q,
  input logic                          end_of_message,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_i,
  input logic signed [SAMPLE_BITS-1:0] out_q,
  input logic                          window_done,
  input logic                          message_done
);

  `CCF_ASSERT_ALWAYS(a_reset_empties_out, rst |=> !out_valid, "output valid after reset")

  `CCF_ASSERT(a_msg_closes_window, (out_valid && message_done) |-> window_done,
    "message_done without window_done")

  `CCF_ASSERT(a_out_holds, (out_valid && !out_ready) |=> (out_valid && $stable(out_i) &&
    $stable(out_q) && $stable(window_done) && $stable(message_done)),
    "stalled output beat changed")

  `CCF_ASSERT(a_in_holds, (in_valid && !in_ready) |=> (in_valid && $stable(sample_i) &&
    $stable(sample_q) && $stable(end_of_message)), "waiting input beat changed")

endmodule

bind block_circular_correlation_filter_top ccf_checker u_ccf_checker (.*);
